### hw/rtl/base64_stream_codec_assert.svh
// Assertion macros for the codec RTL.
`ifndef BASE64_STREAM_CODEC_ASSERT_SVH
`define BASE64_STREAM_CODEC_ASSERT_SVH

`ifndef SYNTHESIS
`define CODEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("codec assertion failed");
`define CODEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("codec assertion failed");
`else
`define CODEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CODEC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/bbsc_pkg.sv
package bbsc_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic [7:0] data;
		logic       has_data;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [2:0]       count;
		result_t [3:0]    res;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] enc_char(input logic [5:0] six);
		logic [7:0] s;
		s = {2'b00, six};
		if (six < 6'd26)
			return 8'(8'h41 + s);
		else if (six < 6'd52)
			return 8'(8'h61 + s - 8'd26);
		else if (six < 6'd62)
			return 8'(8'h30 + s - 8'd52);
		else if (six == 6'd62)
			return 8'h2B;
		else
			return 8'h2F;
	endfunction

	function automatic logic [5:0] char_value(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A)
			return 6'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A)
			return 6'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39)
			return 6'(c - 8'h30 + 8'd52);
		else if (c == 8'h2B)
			return 6'd62;
		else if (c == 8'h2F)
			return 6'd63;
		else
			return 6'd0;
	endfunction

endpackage

### hw/rtl/base64_stream_codec.sv
// Streaming Base64 codec (standard alphabet). cfg_data selects the mode: 0 encodes raw
// bytes into characters, 1 decodes characters into bytes; a write clears the grouping.
// An input beat is accepted whenever the command queue (QUEUE_DEPTH entries)
// has room; each beat yields up to four results, which leave one per cycle through the
// output register while m_tready is high. Encoding settles at four characters per
// three bytes, its rate set by the one-result-per-cycle output stage. m_tuser low
// marks a bare end-of-message beat.
module base64_stream_codec import bbsc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,   // mode
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] data_in
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] data_out
	output logic       m_tlast,
	output logic       m_tuser     // [0] has_data
);

`include "base64_stream_codec_assert.svh"

	logic      push;
	logic      pop;
	cmd_t      push_cmd;
	cmd_t      head;
	q_status_t q_stat;

	assign cfg_ready = 1'b1;

	bbsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	bbsc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.q_stat  (q_stat)
	);

	bbsc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_stat  (q_stat),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	`CODEC_ASSERT_IMPLY(a_full_blocks_input, clk, arst_n, q_stat.full, !s_tready && !push)
	`CODEC_ASSERT_IMPLY(a_pop_needs_slot, clk, arst_n, pop, !q_stat.empty && (!m_tvalid || m_tready))
	`CODEC_ASSERT_IMPLY(a_bare_is_last, clk, arst_n, m_tvalid && !m_tuser, m_tlast)
	`CODEC_ASSERT_NEXT(a_load_shows_valid, clk, arst_n, !q_stat.empty && m_tready, m_tvalid)

endmodule

### hw/rtl/bbsc_front.sv
module bbsc_front import bbsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_data,
	input  logic       s_tvalid,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	output logic       s_tready,
	input  q_status_t  q_stat,
	output logic       push,
	output cmd_t       push_cmd
);

	logic       mode_q;
	logic [1:0] gp_q;
	logic [5:0] left_q;
	logic [1:0] gp_nx;
	logic [5:0] left_nx;
	logic       accept;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && (push_cmd.count != 3'd0);

	always_comb begin
		logic [5:0] v;
		logic       pad;
		logic [7:0] byte_v;
		logic       have;
		logic [2:0] n;
		byte_v   = 8'h00;
		have     = 1'b0;
		n        = 3'd0;
		v        = char_value(s_tdata);
		pad      = (s_tdata == PAD_CHAR);
		gp_nx    = gp_q;
		left_nx  = left_q;
		push_cmd = '0;
		if (mode_q == MODE_ENCODE) begin
			case (gp_q)
				2'd1: begin
					push_cmd.res[0].data = enc_char({left_q[1:0], s_tdata[7:4]});
					push_cmd.res[0].has_data = 1'b1;
					left_nx = {2'b00, s_tdata[3:0]};
					gp_nx = 2'd2;
					n = 3'd1;
					if (s_tlast) begin
						push_cmd.res[1].data = enc_char({s_tdata[3:0], 2'b00});
						push_cmd.res[1].has_data = 1'b1;
						push_cmd.res[2].data = PAD_CHAR;
						push_cmd.res[2].has_data = 1'b1;
						n = 3'd3;
					end
				end
				2'd2: begin
					push_cmd.res[0].data = enc_char({left_q[3:0], s_tdata[7:6]});
					push_cmd.res[0].has_data = 1'b1;
					push_cmd.res[1].data = enc_char(s_tdata[5:0]);
					push_cmd.res[1].has_data = 1'b1;
					left_nx = 6'd0;
					gp_nx = 2'd0;
					n = 3'd2;
				end
				default: begin
					push_cmd.res[0].data = enc_char(s_tdata[7:2]);
					push_cmd.res[0].has_data = 1'b1;
					left_nx = {4'b0000, s_tdata[1:0]};
					gp_nx = 2'd1;
					n = 3'd1;
					if (s_tlast) begin
						push_cmd.res[1].data = enc_char({s_tdata[1:0], 4'b0000});
						push_cmd.res[1].has_data = 1'b1;
						push_cmd.res[2].data = PAD_CHAR;
						push_cmd.res[2].has_data = 1'b1;
						push_cmd.res[3].data = PAD_CHAR;
						push_cmd.res[3].has_data = 1'b1;
						n = 3'd4;
					end
				end
			endcase
		end else begin
			case (gp_q)
				2'd0: begin
					left_nx = v;
					gp_nx = 2'd1;
				end
				2'd1: begin
					byte_v = {left_q, v[5:4]};
					left_nx = {2'b00, v[3:0]};
					gp_nx = 2'd2;
					have = 1'b1;
				end
				2'd2: begin
					byte_v = {left_q[3:0], v[5:2]};
					left_nx = {4'b0000, v[1:0]};
					gp_nx = 2'd3;
					have = 1'b1;
				end
				default: begin
					byte_v = {left_q[1:0], v};
					left_nx = 6'd0;
					gp_nx = 2'd0;
					have = 1'b1;
				end
			endcase
			if (have && !pad) begin
				push_cmd.res[0].data = byte_v;
				push_cmd.res[0].has_data = 1'b1;
				n = 3'd1;
			end else if (s_tlast) begin
				n = 3'd1;
			end
		end
		push_cmd.count = n;
		for (int i = 0; i < 4; i++)
			push_cmd.res[i].last = s_tlast && (3'(i) == 3'(n - 3'd1));
		if (s_tlast) begin
			gp_nx = 2'd0;
			left_nx = 6'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCODE;
			gp_q   <= 2'd0;
			left_q <= 6'd0;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
			gp_q   <= 2'd0;
			left_q <= 6'd0;
		end else if (accept) begin
			gp_q   <= gp_nx;
			left_q <= left_nx;
		end
	end

endmodule

### hw/rtl/bbsc_queue.sv
module bbsc_queue import bbsc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign head         = mem_q[rd_q];
	assign q_stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_q + 1'b1);
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_q + 1'b1);
			if (push && !pop)
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			else if (pop && !push)
				cnt_q <= CNT_W'(cnt_q - 1'b1);
		end
	end

endmodule

### hw/rtl/bbsc_back.sv
module bbsc_back import bbsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  q_status_t  q_stat,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic       m_tuser
);

	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;
	logic       m_tuser_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_end;
	result_t    cur;

	assign cur      = head.res[idx_q];
	assign load     = !q_stat.empty && (!m_tvalid_q || m_tready);
	assign at_end   = ({1'b0, idx_q} == 3'(head.count - 3'd1));
	assign pop      = load && at_end;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			idx_q      <= 2'd0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
			idx_q      <= at_end ? 2'd0 : 2'(idx_q + 2'd1);
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= cur.data;
			m_tlast_q <= cur.last;
			m_tuser_q <= cur.has_data;
		end
	end

endmodule
